// ===== rtl/core/framebuffer_pixel_unpacker_assert.svh =====
// Assertion macros shared by the framebuffer pixel unpacker RTL.
// Depends on nothing; included by the top level only.
`ifndef FRAMEBUFFER_PIXEL_UNPACKER_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_UNPACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framebuffer_pixel_unpacker: assertion failed");

// Next-cycle implication, checked outside reset.
`define FBPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framebuffer_pixel_unpacker: assertion failed");

`endif

// ===== rtl/core/fbpu_pkg.sv =====
// Types and constants of the framebuffer pixel unpacker.
// Used by fbpu_emit and framebuffer_pixel_unpacker; depends on nothing.
package fbpu_pkg;

  localparam int BUF_BYTES = 2048;
  localparam int ADDR_W    = 11;

  typedef enum logic [1:0] {
    REG_HIGH_RES = 2'd0,
    REG_LARGE    = 2'd1,
    REG_COLOR    = 2'd2,
    REG_FG       = 2'd3
  } reg_idx_t;

  // Mode settings seen by the pixel emitter.
  typedef struct packed {
    logic       high_res;
    logic       color_en;
    logic [3:0] fg_color;
  } mode_t;

  // One changed byte handed to the emitter.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] offset;
    logic [7:0]        data;
  } load_t;

  // Emitter status back to the compare stage.
  typedef struct packed {
    logic busy;
    logic can_load;
  } emit_stat_t;

endpackage

// ===== rtl/core/framebuffer_pixel_unpacker.sv =====
// Framebuffer pixel unpacker. After reset the 2048-byte shadow memory is
// cleared one byte per cycle, in_tready staying low meanwhile (configuration
// writes are taken throughout). A byte beat is compared with the shadow in
// the cycle after it is taken; an unchanged or out-of-range byte causes no
// output and the next beat can enter every cycle. A changed byte is written
// back and unpacked at one pixel beat per cycle unless the output stalls:
// eight beats in high-resolution mode, two in normal mode. The emitter sets
// the sustained rate and loads a new byte as its last beat fires. Depends on
// fbpu_pkg, fbpu_ram, fbpu_emit and framebuffer_pixel_unpacker_assert.svh.
module framebuffer_pixel_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // From bit 0: offset[10:0], byte_value[7:0], zero pad.
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // From bit 0: pixel_x[6:0], pixel_y[6:0], color_index[3:0],
  // red_level[7:0], green_level[7:0], blue_level[7:0], zero pad.
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  localparam int AW = fbpu_pkg::ADDR_W;

  // Configuration registers.
  logic       high_res_r, large_r, color_r;
  logic [3:0] fg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_res_r <= 1'b0;
      large_r    <= 1'b0;
      color_r    <= 1'b0;
      fg_r       <= 4'd0;
    end else if (cfg_wr_en) begin
      unique case (fbpu_pkg::reg_idx_t'(cfg_addr))
        fbpu_pkg::REG_HIGH_RES: high_res_r <= cfg_wr_data[0];
        fbpu_pkg::REG_LARGE:    large_r    <= cfg_wr_data[0];
        fbpu_pkg::REG_COLOR:    color_r    <= cfg_wr_data[0];
        fbpu_pkg::REG_FG:       fg_r       <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clearing pass over the shadow after reset.
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Compare stage and forwarding of the most recent shadow write.
  logic          s1_valid_r;
  logic [AW-1:0] s1_off_r;
  logic [7:0]    s1_byte_r;
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [7:0]    fwd_data_r;

  logic          accept, in_range, emit_req, s1_wr, s1_adv;
  logic [7:0]    ram_rd, old_byte;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  fbpu_pkg::load_t      ld;
  fbpu_pkg::emit_stat_t em_stat;
  fbpu_pkg::mode_t      mode;

  assign accept   = in_tvalid && in_tready;
  assign old_byte = (fwd_valid_r && fwd_addr_r == s1_off_r) ? fwd_data_r : ram_rd;
  assign in_range = large_r || (s1_off_r[AW-1:AW-2] == 2'b00);
  assign emit_req = s1_valid_r && in_range && (old_byte != s1_byte_r);
  assign s1_wr    = emit_req && em_stat.can_load;
  assign s1_adv   = !s1_valid_r || !emit_req || em_stat.can_load;

  assign in_tready = !clr_busy_r && s1_adv;

  assign ram_we    = clr_busy_r || s1_wr;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_off_r;
  assign ram_wdata = clr_busy_r ? 8'd0 : s1_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= accept;
      end
      if (s1_wr) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_off_r  <= in_tdata[AW-1:0];
      s1_byte_r <= in_tdata[AW+7:AW];
    end
    if (s1_wr) begin
      fwd_addr_r <= s1_off_r;
      fwd_data_r <= s1_byte_r;
    end
  end

  fbpu_ram #(
    .WIDTH(8),
    .DEPTH(fbpu_pkg::BUF_BYTES)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_tdata[AW-1:0]),
    .rdata (ram_rd)
  );

  assign ld.valid  = s1_wr;
  assign ld.offset = s1_off_r;
  assign ld.data   = s1_byte_r;

  assign mode.high_res = high_res_r;
  assign mode.color_en = color_r;
  assign mode.fg_color = fg_r;

  fbpu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode),
    .ld         (ld),
    .stat       (em_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`include "framebuffer_pixel_unpacker_assert.svh"

  // Nothing leaves the block while the shadow is still being cleared.
  `FBPU_ASSERT_IMP(a_quiet_clear, clk, rst_n, clr_busy_r, !out_tvalid && !s1_valid_r)
  // A shadow update never collides with the clearing pass.
  `FBPU_ASSERT_IMP(a_wr_excl, clk, rst_n, s1_wr, !clr_busy_r)
  // A changed byte always leaves the emitter busy with it.
  `FBPU_ASSERT_NXT(a_load_busy, clk, rst_n, ld.valid, em_stat.busy)

endmodule

// ===== rtl/core/fbpu_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module fbpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fbpu_emit.sv =====
// Pixel emitter: unpacks one changed byte into two or eight pixel beats.
// Depends on fbpu_pkg.
module fbpu_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbpu_pkg::mode_t             mode,
  input  fbpu_pkg::load_t             ld,
  output fbpu_pkg::emit_stat_t        stat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // From bit 0: pixel_x[6:0], pixel_y[6:0], color_index[3:0],
  // red_level[7:0], green_level[7:0], blue_level[7:0], zero pad.
  output logic [47:0]                 out_tdata,
  output logic                        out_tlast
);

  localparam logic [7:0] GREY [16] = '{
    8'd30,  8'd43,  8'd56,  8'd70,  8'd83,  8'd96,  8'd110, 8'd123,
    8'd136, 8'd150, 8'd163, 8'd176, 8'd190, 8'd203, 8'd216, 8'd230
  };

  // One colour channel of the HBGR palette; indexes 0 and 8 are both black.
  function automatic logic [7:0] hbgr_level(input logic [3:0] c, input logic b);
    logic [7:0] lvl;
    lvl = 8'd30;
    if (c[2:0] != 3'd0) begin
      lvl = 8'd30 + (b ? 8'd120 : 8'd0) + (c[3] ? 8'd80 : 8'd0);
    end
    return lvl;
  endfunction

  logic                        busy_r, busy_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic [fbpu_pkg::ADDR_W-1:0] off_r;
  logic [7:0]                  data_r;
  logic                        ov_r, ov_nxt;
  logic [47:0]                 od_r;
  logic                        ol_r;

  logic       fire, is_last;
  logic [6:0] px, py;
  logic [3:0] pc;
  logic [7:0] lr, lg, lb;

  assign fire    = busy_r && (!ov_r || out_tready);
  assign is_last = mode.high_res ? (cnt_r == 3'd7) : (cnt_r == 3'd1);

  assign stat.busy     = busy_r;
  assign stat.can_load = !busy_r || (fire && is_last);

  always_comb begin
    if (mode.high_res) begin
      px = {off_r[9], off_r[3:0], 2'b00} + {5'd0, cnt_r[2], cnt_r[0]};
      py = {off_r[10], off_r[8:4], cnt_r[1]};
      pc = data_r[cnt_r] ? mode.fg_color : 4'd0;
    end else begin
      px = {1'b0, off_r[9], off_r[3:0], cnt_r[0]};
      py = {1'b0, off_r[10], off_r[8:4]};
      pc = cnt_r[0] ? data_r[7:4] : data_r[3:0];
    end
    if (mode.color_en) begin
      lr = hbgr_level(pc, pc[0]);
      lg = hbgr_level(pc, pc[1]);
      lb = hbgr_level(pc, pc[2]);
    end else begin
      lr = GREY[pc];
      lg = GREY[pc];
      lb = GREY[pc];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (fire) begin
      ov_nxt  = 1'b1;
      cnt_nxt = cnt_r + 3'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (ld.valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.valid) begin
      off_r  <= ld.offset;
      data_r <= ld.data;
    end
    if (fire) begin
      od_r <= {6'd0, lb, lg, lr, pc, py, px};
      ol_r <= is_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule
